>>> rtl/trct_pkg.sv
`default_nettype none

package trct_pkg;

  // One input item as it crosses the input channel.
  typedef struct packed {
    logic        mode;
    logic [31:0] type_id;
    logic [7:0]  version;
    logic [31:0] hash;
  } item_t;

  // One result item as it crosses the output channel.
  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [7:0]  stored_version;
    logic [31:0] stored_hash;
    logic [1:0]  compat;
    logic [4:0]  entry_count;
  } result_t;

  // One registry entry as it is kept in the table memory.
  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  version;
    logic [31:0] hash;
  } entry_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } state_e;

  // Item modes.
  localparam logic ModeRegister = 1'b0;
  localparam logic ModeCheck    = 1'b1;

  // Status codes.
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusZeroId   = 2'd1;
  localparam logic [1:0] StatusFull     = 2'd2;
  localparam logic [1:0] StatusNotFound = 2'd3;

  // Compatibility codes.
  localparam logic [1:0] CompatUnknown      = 2'd0;
  localparam logic [1:0] CompatIdentical    = 2'd1;
  localparam logic [1:0] CompatCompatible   = 2'd2;
  localparam logic [1:0] CompatIncompatible = 2'd3;

  // Classifies the caller's version and hash against a stored entry.
  function automatic logic [1:0] classify(input logic [7:0]  caller_ver,
                                          input logic [31:0] caller_hash,
                                          input logic [7:0]  our_ver,
                                          input logic [31:0] our_hash);
    logic any_zero;
    logic ver_eq;
    logic [1:0] res;
    any_zero = (caller_hash == 32'd0) || (our_hash == 32'd0);
    ver_eq   = (caller_ver == our_ver);
    if (!any_zero && (caller_hash == our_hash)) begin
      res = CompatIdentical;
    end else if (any_zero) begin
      res = ver_eq ? CompatIdentical : CompatCompatible;
    end else if (!ver_eq) begin
      res = CompatCompatible;
    end else begin
      res = CompatIncompatible;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/trct_ram.sv
`default_nettype none

module trct_ram #(
  parameter int unsigned Width = 72,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/type_registry_compat_table_unit.sv
`default_nettype none

// An accepted item compares one table slot per cycle until its id is found or all
// occupied slots are seen; a zero id or an empty table ends the scan on its first step.
// The result is then held until the output accepts it. Input is not ready meanwhile,
// so a new item is taken only once the last result has gone out.
// Reset clears the entry count and the sequencer; table contents need no clearing.
module type_registry_compat_table_unit #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire trct_pkg::item_t  in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output trct_pkg::result_t     out_data_o
);

  import trct_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned EW = $bits(entry_t);

  state_e          state_q, state_d;
  item_t           item_q, item_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   occ_q, occ_d;
  result_t         out_q, out_d;

  logic            we;
  logic [AW-1:0]   waddr;
  entry_t          wdata;
  logic [AW-1:0]   raddr;
  entry_t          rdata;
  logic [EW-1:0]   rdata_raw;

  assign rdata = entry_t'(rdata_raw);

  // Table memory holding key, version and hash of every slot.
  trct_ram #(
    .Width (EW),
    .Depth (MAX_ENTRIES),
    .AddrW (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (EW'(wdata)),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
      occ_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      occ_q   <= occ_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
  end

  // Sequencer: latch the item, scan slots one per cycle, then hold the result.
  always_comb begin
    logic    hit;
    logic    last;
    logic    full;
    result_t res;

    state_d     = state_q;
    item_d      = item_q;
    idx_d       = idx_q;
    occ_d       = occ_q;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = idx_q;
    wdata.key   = item_q.type_id;
    wdata.version = item_q.version;
    wdata.hash  = item_q.hash;
    raddr       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    hit  = (occ_q != '0) && (rdata.key == item_q.type_id);
    last = (occ_q == '0) || ((CW'(idx_q) + CW'(1)) == occ_q);
    full = (occ_q == CW'(MAX_ENTRIES));
    res  = '0;

    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d  = in_data_i;
          idx_d   = '0;
          raddr   = '0;
          state_d = StScan;
        end
      end

      StScan: begin
        priority if (item_q.type_id == 32'd0) begin
          res.status = StatusZeroId;
          state_d    = StDone;
        end else if (hit) begin
          // The slot at idx_q holds this id.
          if (item_q.mode == ModeRegister) begin
            we    = 1'b1;
            waddr = idx_q;
            res.status = StatusOk;
          end else begin
            res.status         = StatusOk;
            res.found          = 1'b1;
            res.stored_version = rdata.version;
            res.stored_hash    = rdata.hash;
            res.compat         = classify(item_q.version, item_q.hash,
                                          rdata.version, rdata.hash);
          end
          state_d = StDone;
        end else if (last) begin
          // No occupied slot holds this id.
          if (item_q.mode == ModeRegister) begin
            if (full) begin
              res.status = StatusFull;
            end else begin
              we    = 1'b1;
              waddr = occ_q[AW-1:0];
              occ_d = occ_q + CW'(1);
              res.status = StatusOk;
            end
          end else begin
            res.status = StatusNotFound;
          end
          state_d = StDone;
        end else begin
          idx_d = idx_q + AW'(1);
          raddr = idx_q + AW'(1);
        end
        if (state_d == StDone) begin
          res.entry_count = 5'(occ_d);
          out_d = res;
        end
      end

      StDone: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

>>> bench/type_registry_compat_table_unit_tb.sv
module type_registry_compat_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trct_pkg::*;

  localparam int TableDepth  = 16;
  localparam int KeyPoolSize = 20;
  localparam int ReportLimit = 10;

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    in_valid_i  = 1'b0;
  logic    in_ready_o;
  item_t   in_data_i   = '0;
  logic    out_valid_o;
  logic    out_ready_i = 1'b0;
  result_t out_data_o;

  // Shadow copy of the registry, updated as each input transfer is accepted.
  logic [31:0] reg_key  [TableDepth];
  logic [7:0]  reg_ver  [TableDepth];
  logic [31:0] reg_hash [TableDepth];
  int unsigned reg_count = 0;

  result_t     expected_results[$];
  logic [31:0] key_pool[KeyPoolSize];
  int          mismatches     = 0;
  int          src_idle_pct   = 0;
  int          sink_stall_pct = 0;
  int          hold_cycles    = 0;

  type_registry_compat_table_unit #(
    .MAX_ENTRIES(TableDepth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Returns the slot that holds the key, or -1 when it is not in the table.
  function automatic int find_entry(input logic [31:0] key);
    for (int i = 0; i < reg_count; i++) begin
      if (reg_key[i] == key) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Grades the caller's schema against the stored one. A zero hash means the
  // hash is absent, so only the versions decide.
  function automatic logic [1:0] grade_schema(input logic [7:0]  caller_ver,
                                              input logic [31:0] caller_hash,
                                              input logic [7:0]  held_ver,
                                              input logic [31:0] held_hash);
    if (caller_hash != '0 && held_hash != '0 && caller_hash == held_hash) begin
      return CompatIdentical;
    end
    if (caller_hash == '0 || held_hash == '0) begin
      return (caller_ver == held_ver) ? CompatIdentical : CompatCompatible;
    end
    return (caller_ver != held_ver) ? CompatCompatible : CompatIncompatible;
  endfunction

  // Applies one item to the shadow registry and returns the result it should give.
  function automatic result_t registry_apply(input item_t it);
    result_t r;
    int      slot;
    r        = '0;
    r.status = StatusOk;
    r.compat = CompatUnknown;
    slot     = find_entry(it.type_id);
    if (it.type_id == '0) begin
      r.status = StatusZeroId;
    end else if (it.mode == ModeRegister) begin
      if (slot >= 0) begin
        reg_ver[slot]  = it.version;
        reg_hash[slot] = it.hash;
      end else if (reg_count >= TableDepth) begin
        r.status = StatusFull;
      end else begin
        reg_key[reg_count]  = it.type_id;
        reg_ver[reg_count]  = it.version;
        reg_hash[reg_count] = it.hash;
        reg_count++;
      end
    end else if (slot < 0) begin
      r.status = StatusNotFound;
    end else begin
      r.found          = 1'b1;
      r.stored_version = reg_ver[slot];
      r.stored_hash    = reg_hash[slot];
      r.compat         = grade_schema(it.version, it.hash,
                                      reg_ver[slot], reg_hash[slot]);
    end
    r.entry_count = 5'(reg_count);
    return r;
  endfunction

  function automatic item_t make_item(input logic mode, input logic [31:0] id,
                                      input logic [7:0] ver, input logic [31:0] hash);
    item_t it;
    it.mode    = mode;
    it.type_id = id;
    it.version = ver;
    it.hash    = hash;
    return it;
  endfunction

  // A nonzero key that is not in the table yet.
  function automatic logic [31:0] fresh_key();
    logic [31:0] k;
    do begin
      k = $urandom;
    end while (k == '0 || find_entry(k) >= 0);
    return k;
  endfunction

  // Random traffic: mostly keys from a small pool so that the table fills and
  // entries get overwritten, plus zero ids and random keys that miss.
  function automatic item_t random_item();
    item_t it;
    int    pick;
    int    slot;
    it.mode = ($urandom_range(0, 1) == 1) ? ModeCheck : ModeRegister;
    pick    = $urandom_range(0, 99);
    if (pick < 4) begin
      it.type_id = '0;
    end else if (pick < 14) begin
      it.type_id = $urandom;
    end else begin
      it.type_id = key_pool[$urandom_range(0, KeyPoolSize - 1)];
    end
    it.version = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) begin
      it.version = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
    end
    it.hash = $urandom;
    if ($urandom_range(0, 4) == 0) begin
      it.hash = '0;
    end
    // Checks of known keys often reuse the stored version or hash so that
    // every compatibility class comes up.
    slot = find_entry(it.type_id);
    if (it.mode == ModeCheck && slot >= 0) begin
      case ($urandom_range(0, 3))
        0: begin
          it.version = reg_ver[slot];
          it.hash    = reg_hash[slot];
        end
        1: begin
          it.version = reg_ver[slot];
        end
        2: begin
          it.hash = reg_hash[slot];
        end
        default: begin
        end
      endcase
    end
    return it;
  endfunction

  function automatic string result_text(input result_t r);
    return $sformatf("status=%0d found=%0d ver=%02h hash=%08h compat=%0d count=%0d",
                     r.status, r.found, r.stored_version, r.stored_hash, r.compat,
                     r.entry_count);
  endfunction

  // Offers one item, with random idle cycles first, and returns at the rising
  // edge where the transfer is accepted.
  task automatic send_item(input item_t it);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do begin
      @(posedge clk_i);
    end while (in_ready_o !== 1'b1);
    expected_results.push_back(registry_apply(it));
  endtask

  // Drops valid and waits until every expected result has arrived.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Receiver: a long hold-off when one is requested, else random stalls.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Compare each output transfer with the oldest expected result.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("%0t: unexpected result: %s", $time, result_text(out_data_o));
        end
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.status !== want.status || out_data_o.found !== want.found ||
            out_data_o.stored_version !== want.stored_version ||
            out_data_o.stored_hash !== want.stored_hash ||
            out_data_o.compat !== want.compat ||
            out_data_o.entry_count !== want.entry_count) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("%0t: expected %s", $time, result_text(want));
            $display("%0t: actual   %s", $time, result_text(out_data_o));
          end
        end
      end
    end
  end

  // Zero ids are rejected for both modes.
  task automatic test_zero_id();
    send_item(make_item(ModeRegister, 32'h0, 8'hFF, 32'hFFFF_FFFF));
    send_item(make_item(ModeCheck, 32'h0, 8'h00, 32'h0));
  endtask

  task automatic test_empty_lookup();
    send_item(make_item(ModeCheck, 32'hFFFF_FFFF, 8'h01, 32'h1));
  endtask

  // Appends at the largest and smallest ids, then overwrites the first entry.
  task automatic test_register_overwrite();
    send_item(make_item(ModeRegister, 32'hFFFF_FFFF, 8'h00, 32'h0));
    send_item(make_item(ModeRegister, 32'h1, 8'hFF, 32'hFFFF_FFFF));
    send_item(make_item(ModeRegister, 32'hFFFF_FFFF, 8'h07, 32'h1234_5678));
    send_item(make_item(ModeCheck, 32'hFFFF_FFFF, 8'h07, 32'h1234_5678));
  endtask

  // Every compatibility class, with the stored hash present and absent.
  task automatic test_compat_classes();
    send_item(make_item(ModeCheck, 32'h1, 8'hFF, 32'hFFFF_FFFF));
    send_item(make_item(ModeCheck, 32'h1, 8'hFE, 32'hFFFF_FFFF));
    send_item(make_item(ModeCheck, 32'h1, 8'hFF, 32'h0));
    send_item(make_item(ModeCheck, 32'h1, 8'h00, 32'h0));
    send_item(make_item(ModeCheck, 32'h1, 8'h00, 32'hDEAD_BEEF));
    send_item(make_item(ModeCheck, 32'h1, 8'hFF, 32'hDEAD_BEEF));
    send_item(make_item(ModeRegister, 32'h2, 8'h09, 32'h0));
    send_item(make_item(ModeCheck, 32'h2, 8'h09, 32'h55));
    send_item(make_item(ModeCheck, 32'h2, 8'h0A, 32'h55));
    send_item(make_item(ModeCheck, 32'h3, 8'h09, 32'h0));
  endtask

  task automatic test_random_traffic(input int count, input int src_pct, input int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (count) begin
      send_item(random_item());
    end
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // block fills up and stalls its input.
  task automatic test_output_stall();
    src_idle_pct = 0;
    @(posedge clk_i);
    hold_cycles = 150;
    repeat (12) begin
      send_item(random_item());
    end
  endtask

  // The sender pauses until everything is out, then resumes.
  task automatic test_drain_pause();
    repeat (5) begin
      send_item(random_item());
    end
    wait_drained();
    repeat (5) begin
      send_item(random_item());
    end
  endtask

  // Fills the table, then a new id is refused while the last slot can still
  // be overwritten and found after a full scan.
  task automatic test_table_full();
    logic [31:0] last_key;
    while (reg_count < TableDepth) begin
      send_item(make_item(ModeRegister, fresh_key(), 8'($urandom_range(0, 255)), $urandom));
    end
    send_item(make_item(ModeRegister, fresh_key(), 8'h11, 32'h2222_3333));
    last_key = reg_key[TableDepth - 1];
    send_item(make_item(ModeRegister, last_key, 8'hA5, 32'h0));
    send_item(make_item(ModeCheck, last_key, 8'hA5, 32'hFFFF_FFFF));
    send_item(make_item(ModeCheck, fresh_key(), 8'hA5, 32'h0));
  endtask

  initial begin
    key_pool[0] = 32'hFFFF_FFFF;
    key_pool[1] = 32'h1;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < KeyPoolSize; i++) begin
      do begin
        key_pool[i] = $urandom;
      end while (key_pool[i] == '0);
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_zero_id();
    test_empty_lookup();
    test_register_overwrite();
    test_compat_classes();
    test_random_traffic(180, 21, 47);
    test_random_traffic(180, 47, 21);
    test_output_stall();
    test_drain_pause();
    test_random_traffic(180, 0, 0);
    test_table_full();

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
